[src/b64d_pkg.sv]
// types, character codes and the alphabet map for the base64url stream decoder
`default_nettype none

package b64d_pkg;

    // character codes
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    // value offsets of the alphabet ranges
    localparam logic [7:0] OFS_LOWER  = 8'd26;
    localparam logic [7:0] OFS_DIGIT  = 8'd52;
    localparam logic [5:0] VAL_PLUS   = 6'd62;
    localparam logic [5:0] VAL_SLASH  = 6'd63;

    // group positions
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // status codes on the last result
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_STOPPED = 1'b1;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_result;
        logic       status;
    } t_result;

    // alphabet map: bit 6 set for a character outside the alphabet
    function automatic logic [6:0] f_sextet(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            v = {1'b0, 6'(c - CH_UPPER_A)};
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            v = {1'b0, 6'(c - CH_LOWER_A + OFS_LOWER)};
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            v = {1'b0, 6'(c - CH_DIGIT_0 + OFS_DIGIT)};
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            v = {1'b0, VAL_PLUS};
        end else if (c == CH_SLASH || c == CH_UNDER) begin
            v = {1'b0, VAL_SLASH};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[src/base64url_stream_decoder.sv]
// top level of the base64url stream decoder: input register, group decode, result queue
//
//   channel  | valid    | stall    | payload
//   ---------+----------+----------+-----------------------------------------------
//   input    | i_valid  | o_stall  | i_char_code, i_end_of_message
//   output   | o_valid  | i_stall  | o_out_byte, o_byte_valid, o_last_result, o_status
//
// one input item is taken per cycle while o_stall is low; an item that ends a message
// after a completed byte gives two results.
// an item is held in the input register, decoded from there and written to the
// result queue, whose head drives the output.
// the four-entry result queue decides when the input stalls.
// reset is synchronous and active low; it clears the group state and the queue.
`default_nettype none

module base64url_stream_decoder
    import b64d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_message,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_last_result,
    output logic            o_status
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eom;

    // group state
    logic [5:0] r_g0, n_g0;
    logic [3:0] r_g1, n_g1;
    logic [1:0] r_g2, n_g2;
    logic       r_third_pad, n_third_pad;
    logic [1:0] r_pos, n_pos;
    logic       r_stopped, n_stopped;

    // result queue
    t_result    r_fifo [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_count;

    // decode signals
    logic [6:0] sext;
    logic [5:0] v;
    logic       bad;
    logic       is_pad;
    logic       emit;
    logic [7:0] byte_val;
    t_result    res_a;
    t_result    res_b;
    logic [1:0] n_res;
    logic       pop;
    logic [2:0] free;
    logic       consume;
    logic       accept;

    assign sext   = f_sextet(r_char);
    assign v      = sext[5:0];
    assign bad    = sext[6];
    assign is_pad = (r_char == CH_PAD);

    // group decode of the registered item
    always_comb begin
        n_g0        = r_g0;
        n_g1        = r_g1;
        n_g2        = r_g2;
        n_third_pad = r_third_pad;
        n_pos       = r_pos;
        n_stopped   = r_stopped;
        emit        = 1'b0;
        byte_val    = '0;
        if (!r_stopped) begin
            unique case (r_pos)
                POS_FIRST: begin
                    if (bad) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_g0  = v;
                        n_pos = POS_SECOND;
                    end
                end
                POS_SECOND: begin
                    if (bad) begin
                        n_stopped = 1'b1;
                    end else begin
                        emit     = 1'b1;
                        byte_val = {r_g0, v[5:4]};
                        n_g1     = v[3:0];
                        n_pos    = POS_THIRD;
                    end
                end
                POS_THIRD: begin
                    if (is_pad) begin
                        n_third_pad = 1'b1;
                        n_g2        = 2'b00;
                        n_pos       = POS_FOURTH;
                    end else if (bad) begin
                        n_stopped = 1'b1;
                    end else begin
                        emit        = 1'b1;
                        byte_val    = {r_g1, v[5:2]};
                        n_third_pad = 1'b0;
                        n_g2        = v[1:0];
                        n_pos       = POS_FOURTH;
                    end
                end
                POS_FOURTH: begin
                    if (!is_pad && bad) begin
                        n_stopped = 1'b1;
                    end else begin
                        if (!is_pad) begin
                            emit     = 1'b1;
                            byte_val = {(r_third_pad ? 2'b00 : r_g2), v};
                        end
                        n_pos       = POS_FIRST;
                        n_third_pad = 1'b0;
                    end
                end
                default: begin
                    n_pos = POS_FIRST;
                end
            endcase
        end

        // end of message: a lone first character counts as a stop
        if (r_eom && !n_stopped && n_pos == POS_SECOND) begin
            n_stopped = 1'b1;
        end
    end

    // order the results of the item: byte first, then the closing result
    always_comb begin
        t_result byte_res;
        t_result last_res;
        byte_res.out_byte    = byte_val;
        byte_res.byte_valid  = 1'b1;
        byte_res.last_result = 1'b0;
        byte_res.status      = ST_DONE;
        last_res.out_byte    = '0;
        last_res.byte_valid  = 1'b0;
        last_res.last_result = 1'b1;
        last_res.status      = n_stopped ? ST_STOPPED : ST_DONE;
        res_a = emit ? byte_res : last_res;
        res_b = last_res;
        n_res = 2'({1'b0, emit} + {1'b0, r_eom});
    end

    // queue space and handshakes
    assign o_valid = (r_count != 3'd0);
    assign pop     = o_valid && !i_stall;
    assign free    = 3'd4 - r_count + {2'b00, pop};
    assign consume = r_in_valid && ({1'b0, n_res} <= free);
    assign o_stall = r_in_valid && !consume;
    assign accept  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_char <= i_char_code;
            r_eom  <= i_end_of_message;
        end
    end

    // group state, cleared at the end of every message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g0        <= '0;
            r_g1        <= '0;
            r_g2        <= '0;
            r_third_pad <= 1'b0;
            r_pos       <= POS_FIRST;
            r_stopped   <= 1'b0;
        end else if (consume) begin
            if (r_eom) begin
                r_g0        <= '0;
                r_g1        <= '0;
                r_g2        <= '0;
                r_third_pad <= 1'b0;
                r_pos       <= POS_FIRST;
                r_stopped   <= 1'b0;
            end else begin
                r_g0        <= n_g0;
                r_g1        <= n_g1;
                r_g2        <= n_g2;
                r_third_pad <= n_third_pad;
                r_pos       <= n_pos;
                r_stopped   <= n_stopped;
            end
        end
    end

    // result queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (consume) begin
                r_wr <= r_wr + n_res;
            end
            if (pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= r_count + (consume ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
        end
    end

    // result queue entries
    always_ff @(posedge i_clk) begin
        if (consume && n_res != 2'd0) begin
            r_fifo[r_wr] <= res_a;
        end
        if (consume && n_res == 2'd2) begin
            r_fifo[r_wr + 2'd1] <= res_b;
        end
    end

    // head of the queue drives the output
    always_comb begin
        t_result head;
        head          = r_fifo[r_rd];
        o_out_byte    = head.out_byte;
        o_byte_valid  = head.byte_valid;
        o_last_result = head.last_result;
        o_status      = head.status;
    end

endmodule

`default_nettype wire
